// File: rtl/cil_pkg.sv
// ----------------------------------------------------------------------------
// cil_pkg
// Shared sizes, field widths and operation codes of the compacting item list.
// ----------------------------------------------------------------------------
package cil_pkg;

    // list size and derived widths
    localparam int CAPACITY = 16;
    localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // stream field widths
    localparam int OPCODE_W = 3;
    localparam int VALUE_W  = 32;
    localparam int DATA_W   = 32;
    localparam int COUNT_W  = 5;
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 40;

    // operation codes
    typedef enum logic [OPCODE_W-1:0] {
        OP_APPEND = 3'd0,
        OP_FIRST  = 3'd1,
        OP_NEXT   = 3'd2,
        OP_FIND   = 3'd3,
        OP_REMOVE = 3'd4,
        OP_CLEAR  = 3'd5
    } op_t;

endpackage

// File: rtl/cil_ram.sv
// ----------------------------------------------------------------------------
// cil_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module cil_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                   aclk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/compacting_item_list.sv
// ----------------------------------------------------------------------------
// compacting_item_list
// Bounded ordered list of words in a RAM with append, cursor reads, find,
// remove with shift-down compaction, and clear.
// ----------------------------------------------------------------------------
// Sequence: append, clear, failing first/next and unknown ops, and any op on
//   an empty list go straight to done; first/next pass a read state; find and
//   remove scan the single RAM read port one entry per cycle, then shift once
//   per later entry. Throughput: one item in flight at a time; the next
//   transfer is taken once the current item has reached the output register.
// Reset: entry count cleared, cursor set to no position; RAM is not cleared.
// ----------------------------------------------------------------------------
module compacting_item_list (
    input  logic                          aclk,
    input  logic                          aresetn,
    // slave: [2:0] opcode, [34:3] value, [39:35] zero
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [cil_pkg::S_TDATA_W-1:0] s_tdata,
    // master: [0] ok, [32:1] data, [37:33] count, [39:38] zero
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [cil_pkg::M_TDATA_W-1:0] m_tdata
);
    import cil_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_SCAN,
        ST_SHIFT,
        ST_DONE
    } state_t;

    state_t               state_reg;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     cur_reg;
    logic                 cur_valid_reg;
    logic [CNT_W-1:0]     idx_reg;
    logic                 remove_reg;
    logic [VALUE_W-1:0]   key_reg;
    logic                 res_ok_reg;
    logic [DATA_W-1:0]    res_data_reg;
    logic                 m_valid_reg;
    logic [M_TDATA_W-1:0] m_data_reg;

    // input decode
    logic               s_xfer;
    op_t                in_op;
    logic [VALUE_W-1:0] in_value;
    assign s_tready = (state_reg == ST_IDLE);
    assign s_xfer   = s_tvalid && s_tready;
    assign in_op    = op_t'(s_tdata[OPCODE_W-1:0]);
    assign in_value = s_tdata[OPCODE_W +: VALUE_W];

    // cursor and scan conditions
    logic             not_full;
    logic             not_empty;
    logic             next_ok;
    logic [CNT_W-1:0] next_pos;
    logic [CNT_W:0]   idx_p1;
    logic [CNT_W:0]   idx_p2;
    logic             more_after;
    logic             more_shift;
    logic             hit;
    logic             out_free;
    assign not_full   = (count_reg < CNT_W'(CAPACITY));
    assign not_empty  = (count_reg != '0);
    assign next_pos   = cur_valid_reg ? cur_reg + CNT_W'(1) : '0;
    assign next_ok    = not_empty && (!cur_valid_reg ||
                        ({1'b0, cur_reg} + (CNT_W+1)'(1) < {1'b0, count_reg}));
    assign idx_p1     = {1'b0, idx_reg} + (CNT_W+1)'(1);
    assign idx_p2     = {1'b0, idx_reg} + (CNT_W+1)'(2);
    assign more_after = (idx_p1 < {1'b0, count_reg});
    assign more_shift = (idx_p2 < {1'b0, count_reg});
    assign out_free   = !m_valid_reg || m_tready;

    // ram ports
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [DATA_W-1:0] ram_wdata;
    logic [ADDR_W-1:0] ram_raddr;
    logic [DATA_W-1:0] ram_rdata;
    assign hit = (ram_rdata == key_reg);

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = count_reg[ADDR_W-1:0];
        ram_wdata = in_value;
        ram_raddr = '0;
        unique case (state_reg)
            ST_IDLE: begin
                ram_we    = s_xfer && (in_op == OP_APPEND) && not_full;
                ram_raddr = (in_op == OP_NEXT) ? next_pos[ADDR_W-1:0] : '0;
            end
            ST_SCAN: begin
                ram_raddr = idx_p1[ADDR_W-1:0];
            end
            ST_SHIFT: begin
                ram_we    = 1'b1;
                ram_waddr = idx_reg[ADDR_W-1:0];
                ram_wdata = ram_rdata;
                ram_raddr = idx_p2[ADDR_W-1:0];
            end
            default: begin
                ram_raddr = '0;
            end
        endcase
    end

    cil_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CAPACITY)
    ) u_entries (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // sequencer, list state and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            cur_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            // output register empties on a transfer unless reloaded in done
            if (m_valid_reg && m_tready && (state_reg != ST_DONE)) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_xfer) begin
                        key_reg      <= in_value;
                        idx_reg      <= '0;
                        res_ok_reg   <= 1'b0;
                        res_data_reg <= '0;
                        remove_reg   <= (in_op == OP_REMOVE);
                        state_reg    <= ST_DONE;
                        unique case (in_op)
                            OP_APPEND: begin
                                if (not_full) begin
                                    count_reg  <= count_reg + CNT_W'(1);
                                    res_ok_reg <= 1'b1;
                                end
                            end
                            OP_FIRST: begin
                                if (not_empty) begin
                                    cur_reg       <= '0;
                                    cur_valid_reg <= 1'b1;
                                    state_reg     <= ST_READ;
                                end
                            end
                            OP_NEXT: begin
                                if (next_ok) begin
                                    cur_reg       <= next_pos;
                                    cur_valid_reg <= 1'b1;
                                    state_reg     <= ST_READ;
                                end
                            end
                            OP_FIND, OP_REMOVE: begin
                                if (not_empty) begin
                                    state_reg <= ST_SCAN;
                                end
                            end
                            OP_CLEAR: begin
                                res_ok_reg <= not_empty;
                                count_reg  <= '0;
                            end
                            default: begin
                                res_ok_reg <= 1'b0;
                            end
                        endcase
                    end
                end
                ST_READ: begin
                    res_ok_reg   <= 1'b1;
                    res_data_reg <= ram_rdata;
                    state_reg    <= ST_DONE;
                end
                ST_SCAN: begin
                    // compare the entry read last cycle with the key
                    if (hit) begin
                        res_ok_reg   <= 1'b1;
                        res_data_reg <= ram_rdata;
                        if (!remove_reg) begin
                            state_reg <= ST_DONE;
                        end else if (more_after) begin
                            state_reg <= ST_SHIFT;
                        end else begin
                            count_reg <= count_reg - CNT_W'(1);
                            state_reg <= ST_DONE;
                        end
                    end else if (more_after) begin
                        idx_reg <= idx_p1[CNT_W-1:0];
                    end else begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_SHIFT: begin
                    // entry idx+1 written into idx, idx+2 read for next step
                    idx_reg <= idx_p1[CNT_W-1:0];
                    if (!more_shift) begin
                        count_reg <= count_reg - CNT_W'(1);
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= {(M_TDATA_W - 1 - DATA_W - COUNT_W)'(0),
                                        COUNT_W'(count_reg), res_data_reg, res_ok_reg};
                        state_reg   <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // checks
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_cursor_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cur_valid_reg |-> (cur_reg < CNT_W'(CAPACITY)))
        else $error("cursor outside list storage");

    a_shift_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SHIFT) |-> more_after)
        else $error("shift step past last stored entry");

    a_done_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && out_free) |=> (m_valid_reg && state_reg == ST_IDLE))
        else $error("finished result not loaded into output register");

    a_scan_needs_entries: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> not_empty)
        else $error("scan running on empty list");

endmodule

// File: sim/compacting_item_list_checker.sv
// ----------------------------------------------------------------------------
// compacting_item_list_checker
// Watches both stream channels of the compacting item list, keeps its own
// copy of the list contents, count and read cursor, predicts the answer to
// every accepted command and compares each returned answer field by field.
// ----------------------------------------------------------------------------
module compacting_item_list_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [cil_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [cil_pkg::M_TDATA_W-1:0] m_tdata,
    output int                            mismatches,
    output int                            outstanding
);
    timeunit 1ns;
    timeprecision 1ps;
    import cil_pkg::*;

    typedef struct packed {
        logic               ok;
        logic [DATA_W-1:0]  data;
        logic [COUNT_W-1:0] count;
    } answer_t;

    // shadow of the list: stored words, number held, read cursor (-1 = none)
    logic [DATA_W-1:0] words [CAPACITY];
    int                list_len;
    int                read_pos;

    answer_t expected_answers [$];
    int      err_total;

    // apply one command to the shadow list and return the answer it gives
    function automatic answer_t list_apply(logic [OPCODE_W-1:0] opc,
                                           logic [VALUE_W-1:0] val);
        answer_t a;
        int      hit;
        a   = '0;
        hit = -1;
        case (opc)
            OP_APPEND: begin
                if (list_len < CAPACITY) begin
                    words[list_len] = val;
                    list_len++;
                    a.ok = 1'b1;
                end
            end
            OP_FIRST: begin
                if (list_len > 0) begin
                    read_pos = 0;
                    a.data   = words[0];
                    a.ok     = 1'b1;
                end
            end
            OP_NEXT: begin
                if (list_len > 0 && read_pos < list_len - 1) begin
                    read_pos++;
                    a.data = words[read_pos];
                    a.ok   = 1'b1;
                end
            end
            OP_FIND, OP_REMOVE: begin
                for (int i = 0; i < list_len; i++)
                    if (hit < 0 && words[i] == val)
                        hit = i;
                if (hit >= 0) begin
                    a.data = words[hit];
                    a.ok   = 1'b1;
                    // compaction: later entries move down one place
                    if (opc == OP_REMOVE) begin
                        for (int j = hit; j + 1 < list_len; j++)
                            words[j] = words[j + 1];
                        list_len--;
                    end
                end
            end
            OP_CLEAR: begin
                if (list_len > 0) begin
                    list_len = 0;
                    a.ok     = 1'b1;
                end
            end
            default: ;
        endcase
        a.count = list_len[COUNT_W-1:0];
        return a;
    endfunction

    // watch both channels at each edge: answers checked, commands predicted
    always @(posedge aclk) begin
        answer_t got;
        answer_t want;
        if (!aresetn) begin
            expected_answers.delete();
            list_len  = 0;
            read_pos  = -1;
            err_total = 0;
        end else begin
            // returned answer against the oldest prediction
            if (m_tvalid && m_tready) begin
                got.ok    = m_tdata[0];
                got.data  = m_tdata[DATA_W:1];
                got.count = m_tdata[DATA_W+COUNT_W:DATA_W+1];
                if (expected_answers.size() == 0) begin
                    $display("%0t: unexpected result ok=%0b data=%08h count=%0d",
                             $time, got.ok, got.data, got.count);
                    err_total++;
                end else begin
                    want = expected_answers.pop_front();
                    if (got.ok !== want.ok) begin
                        $display("%0t: ok mismatch expected %0b actual %0b",
                                 $time, want.ok, got.ok);
                        err_total++;
                    end
                    if (got.data !== want.data) begin
                        $display("%0t: data mismatch expected %08h actual %08h",
                                 $time, want.data, got.data);
                        err_total++;
                    end
                    if (got.count !== want.count) begin
                        $display("%0t: count mismatch expected %0d actual %0d",
                                 $time, want.count, got.count);
                        err_total++;
                    end
                end
            end
            // accepted command
            if (s_tvalid && s_tready)
                expected_answers.push_back(
                    list_apply(s_tdata[OPCODE_W-1:0],
                               s_tdata[OPCODE_W+VALUE_W-1:OPCODE_W]));
        end
        mismatches  <= err_total;
        outstanding <= expected_answers.size();
    end

endmodule

// File: sim/compacting_item_list_tb.sv
// ----------------------------------------------------------------------------
// compacting_item_list_tb
// Drives the compacting item list with a directed opening (empty list, cursor
// walks, hits, misses, middle, end and sole-entry removal, clear, unused opcodes)
// and then random command sequences drawn from a small key pool so finds and
// removes hit often, with random idle and stall on both channels.
// ----------------------------------------------------------------------------
module compacting_item_list_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import cil_pkg::*;

    localparam int               TARGET_CMDS = 1200;
    localparam int               HOLD_CYCLES = 300;
    localparam int               CYCLE_LIMIT = 1000000;
    localparam int               TAIL_CYCLES = 64;
    localparam logic [OPCODE_W-1:0] OP_UNUSED_A = 3'd6;
    localparam logic [OPCODE_W-1:0] OP_UNUSED_B = 3'd7;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;

    int          mismatches;
    int          outstanding;
    int          cmds_sent;
    int          cycle_cnt;
    bit          no_gaps;
    bit          hold_request;
    logic [31:0] key_pool [8];

    always #5 aclk = ~aclk;

    compacting_item_list DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    compacting_item_list_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // idle length: mostly none or short, now and then long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // key or word: mostly from the pool so searches hit
    function automatic logic [31:0] pick_value();
        if ($urandom_range(0, 4) == 0) return $urandom();
        return key_pool[$urandom_range(0, 7)];
    endfunction

    task automatic refresh_pool();
        foreach (key_pool[k]) key_pool[k] = $urandom();
    endtask

    // offer one command and hold it until the transfer completes
    task automatic send_cmd(logic [OPCODE_W-1:0] opc, logic [VALUE_W-1:0] val);
        int gap;
        gap = no_gaps ? 0 : idle_len();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W-OPCODE_W-VALUE_W){1'b0}}, val, opc};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        cmds_sent++;
    endtask

    // stop offering and wait until every answer is back
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
    endtask

    // run limit
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // result side: random stall, quiet stretches, one long hold-off
    initial begin
        int stall;
        m_tready <= 1'b0;
        @(posedge aclk);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else if ($urandom_range(0, 19) == 0) begin
                m_tready <= 1'b1;
                repeat (40) @(posedge aclk);
            end else begin
                stall = idle_len();
                if (stall > 0) begin
                    m_tready <= 1'b0;
                    repeat (stall) @(posedge aclk);
                end
                m_tready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    // command side: reset, directed opening, random sequences, verdict
    initial begin
        bit hold_done;
        cycle_cnt    = 0;
        cmds_sent    = 0;
        no_gaps      = 1'b0;
        hold_request = 1'b0;
        hold_done    = 1'b0;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        refresh_pool();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty list: every read, search and clear fails
        send_cmd(OP_NEXT,     32'h0000_0000);
        send_cmd(OP_FIRST,    32'hFFFF_FFFF);
        send_cmd(OP_FIND,     32'h0000_0000);
        send_cmd(OP_REMOVE,   32'hFFFF_FFFF);
        send_cmd(OP_CLEAR,    32'h0000_0000);
        send_cmd(OP_UNUSED_A, 32'h0000_0000);
        send_cmd(OP_UNUSED_B, 32'hFFFF_FFFF);
        // three entries, walk from no position past the end
        send_cmd(OP_APPEND,   32'h0000_0000);
        send_cmd(OP_APPEND,   32'hFFFF_FFFF);
        send_cmd(OP_APPEND,   32'h5A5A_5A5A);
        send_cmd(OP_NEXT,     32'h0);
        send_cmd(OP_NEXT,     32'h0);
        send_cmd(OP_NEXT,     32'h0);
        send_cmd(OP_NEXT,     32'h0);
        send_cmd(OP_FIRST,    32'h0);
        send_cmd(OP_FIND,     32'hFFFF_FFFF);
        send_cmd(OP_FIND,     32'h1234_5678);
        send_cmd(OP_UNUSED_A, 32'h5A5A_5A5A);
        // remove from the middle, the end, then the only entry
        send_cmd(OP_REMOVE,   32'hFFFF_FFFF);
        send_cmd(OP_REMOVE,   32'h5A5A_5A5A);
        send_cmd(OP_REMOVE,   32'h1234_5678);
        send_cmd(OP_REMOVE,   32'h0000_0000);
        send_cmd(OP_APPEND,   32'hA5A5_A5A5);
        send_cmd(OP_CLEAR,    32'h0);
        drain();

        // random command sequences
        while (cmds_sent < TARGET_CMDS) begin
            if (!hold_done && cmds_sent >= 300) begin
                hold_request = 1'b1;
                hold_done    = 1'b1;
            end
            no_gaps = ($urandom_range(0, 4) == 0);
            case ($urandom_range(0, 9))
                0, 1, 2: repeat ($urandom_range(1, 20)) send_cmd(OP_APPEND, pick_value());
                3, 4: begin
                    send_cmd(OP_FIRST, $urandom());
                    repeat ($urandom_range(1, 18)) send_cmd(OP_NEXT, $urandom());
                end
                5, 6: repeat ($urandom_range(1, 6))
                    send_cmd($urandom_range(0, 1) ? OP_FIND : OP_REMOVE, pick_value());
                7: send_cmd(OP_CLEAR, $urandom());
                8: repeat ($urandom_range(1, 4))
                    send_cmd(OPCODE_W'($urandom_range(0, 7)), $urandom());
                default: begin
                    drain();
                    refresh_pool();
                end
            endcase
        end

        // wind down
        drain();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatches == 0 && outstanding == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// File: filelist.f
rtl/cil_pkg.sv
rtl/cil_ram.sv
rtl/compacting_item_list.sv
sim/compacting_item_list_checker.sv
sim/compacting_item_list_tb.sv
